### hw/rtl/olar_pkg.sv
// ----------------------------------------------------------------------------
// olar_pkg
// types and constants shared by the ordered list controller and datapath
// ----------------------------------------------------------------------------
package olar_pkg;

  localparam int unsigned OUT_VAL_W = 32;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned LEN_W     = 5;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_REPORT = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REPORT    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RES_ECHO     = 2'd0,
    RES_EMPTY    = 2'd1,
    RES_DISTINCT = 2'd2
  } res_kind_e;

  typedef struct packed {
    op_e                          opcode;
    logic signed [OUT_VAL_W-1:0]  item_value;
  } in_item_t;

  typedef struct packed {
    status_e                      status;
    logic signed [OUT_VAL_W-1:0]  entry_value;
    logic        [OCC_W-1:0]      occurrences;
    logic        [LEN_W-1:0]      list_length;
    logic                         last_result;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic      capture;
    logic      ent_wr_append;
    logic      ent_wr_shift;
    logic      ent_rd_next;
    logic      ptr_inc;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      cur_load;
    logic      j_clr;
    logic      j_inc;
    logic      dst_wr_new;
    logic      dst_wr_inc;
    logic      emit;
    res_kind_e res_kind;
    status_e   res_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic ptr_at_cnt;
    logic ptr_next_at_cnt;
    logic ent_match;
    logic j_at_nd;
    logic dst_match;
    logic j_last;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/olar_ctrl.sv
// ----------------------------------------------------------------------------
// olar_ctrl
// sequencer for append, remove-and-shift and distinct-count report
// ----------------------------------------------------------------------------
module olar_ctrl
  import olar_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  op_e  in_opcode_i,
  input  sts_t sts_i,
  output logic in_stall_o,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPEND,
    S_RM_RD,
    S_RM_CHK,
    S_SH_RD,
    S_SH_WR,
    S_EMIT,
    S_EMPTY,
    S_RP_ENT_RD,
    S_RP_ENT_WAIT,
    S_RP_DST_RD,
    S_RP_DST_CHK,
    S_RP_NEXT,
    S_RP_OUT_RD,
    S_RP_OUT_EMIT
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.res_kind   = RES_ECHO;
    cmd_o.res_status = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (in_opcode_i)
            OP_APPEND: state_d = S_APPEND;
            OP_REMOVE: state_d = S_RM_RD;
            OP_REPORT: state_d = sts_i.cnt_zero ? S_EMPTY : S_RP_ENT_RD;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_APPEND: begin
        if (sts_i.full) begin
          status_d = ST_FULL;
        end else begin
          cmd_o.ent_wr_append = 1'b1;
          cmd_o.cnt_inc       = 1'b1;
          status_d            = ST_APPENDED;
        end
        state_d = S_EMIT;
      end
      S_RM_RD: begin
        if (sts_i.ptr_at_cnt) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_EMIT;
        end else begin
          state_d = S_RM_CHK;
        end
      end
      S_RM_CHK: begin
        if (sts_i.ent_match) begin
          state_d = S_SH_RD;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_RM_RD;
        end
      end
      S_SH_RD: begin
        cmd_o.ent_rd_next = 1'b1;
        if (sts_i.ptr_next_at_cnt) begin
          cmd_o.cnt_dec = 1'b1;
          status_d      = ST_REMOVED;
          state_d       = S_EMIT;
        end else begin
          state_d = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.ent_wr_shift = 1'b1;
        cmd_o.ptr_inc      = 1'b1;
        state_d            = S_SH_RD;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_EMPTY: begin
        cmd_o.res_kind   = RES_EMPTY;
        cmd_o.res_status = ST_REPORT;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_RP_ENT_RD: begin
        state_d = S_RP_ENT_WAIT;
      end
      S_RP_ENT_WAIT: begin
        cmd_o.cur_load = 1'b1;
        cmd_o.j_clr    = 1'b1;
        state_d        = S_RP_DST_RD;
      end
      S_RP_DST_RD: begin
        if (sts_i.j_at_nd) begin
          cmd_o.dst_wr_new = 1'b1;
          cmd_o.ptr_inc    = 1'b1;
          state_d          = S_RP_NEXT;
        end else begin
          state_d = S_RP_DST_CHK;
        end
      end
      S_RP_DST_CHK: begin
        if (sts_i.dst_match) begin
          cmd_o.dst_wr_inc = 1'b1;
          cmd_o.ptr_inc    = 1'b1;
          state_d          = S_RP_NEXT;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = S_RP_DST_RD;
        end
      end
      S_RP_NEXT: begin
        if (sts_i.ptr_at_cnt) begin
          cmd_o.j_clr = 1'b1;
          state_d     = S_RP_OUT_RD;
        end else begin
          state_d = S_RP_ENT_RD;
        end
      end
      S_RP_OUT_RD: begin
        state_d = S_RP_OUT_EMIT;
      end
      S_RP_OUT_EMIT: begin
        cmd_o.res_kind   = RES_DISTINCT;
        cmd_o.res_status = ST_REPORT;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.j_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.j_inc = 1'b1;
            state_d     = S_RP_OUT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_APPENDED;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

### hw/rtl/olar_dp.sv
// ----------------------------------------------------------------------------
// olar_dp
// entry store, distinct table, counters, comparators and result register
// ----------------------------------------------------------------------------
module olar_dp
  import olar_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  cmd_t      cmd_i,
  input  logic      out_stall_i,
  output sts_t      sts_o,
  output logic      out_valid_o,
  output out_item_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    cnt_t occ;
    val_t value;
  } dst_entry_t;

  val_t       ent_mem [DEPTH];
  dst_entry_t dst_mem [DEPTH];

  val_t       val_q;
  val_t       cur_q;
  val_t       ent_rd_q;
  dst_entry_t dst_rd_q;
  cnt_t       count_q, count_d;
  cnt_t       ptr_q, ptr_d;
  cnt_t       j_q, j_d;
  cnt_t       nd_q, nd_d;
  cnt_t       ptr_nx;
  cnt_t       j_nx;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_data_q, out_data_d;

  logic            ent_we;
  logic [IDX_W-1:0] ent_waddr;
  val_t            ent_wdata;
  logic [IDX_W-1:0] ent_raddr;
  logic            dst_we;
  logic [IDX_W-1:0] dst_waddr;
  dst_entry_t      dst_wdata;

  function automatic logic [OUT_VAL_W-1:0] to_out(val_t v);
    return OUT_VAL_W'(v);
  endfunction

  assign ptr_nx = ptr_q + cnt_t'(1);
  assign j_nx   = j_q + cnt_t'(1);

  // entry store ports
  assign ent_we    = cmd_i.ent_wr_append | cmd_i.ent_wr_shift;
  assign ent_waddr = cmd_i.ent_wr_append ? count_q[IDX_W-1:0] : ptr_q[IDX_W-1:0];
  assign ent_wdata = cmd_i.ent_wr_append ? val_q : ent_rd_q;
  assign ent_raddr = cmd_i.ent_rd_next ? ptr_nx[IDX_W-1:0] : ptr_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rd_q <= ent_mem[ent_raddr];
  end

  // distinct table ports
  assign dst_we    = cmd_i.dst_wr_new | cmd_i.dst_wr_inc;
  assign dst_waddr = cmd_i.dst_wr_new ? nd_q[IDX_W-1:0] : j_q[IDX_W-1:0];
  always_comb begin
    if (cmd_i.dst_wr_new) begin
      dst_wdata.occ   = cnt_t'(1);
      dst_wdata.value = cur_q;
    end else begin
      dst_wdata.occ   = dst_rd_q.occ + cnt_t'(1);
      dst_wdata.value = dst_rd_q.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dst_we) begin
      dst_mem[dst_waddr] <= dst_wdata;
    end
    dst_rd_q <= dst_mem[j_q[IDX_W-1:0]];
  end

  // counters
  always_comb begin
    count_d = count_q;
    ptr_d   = ptr_q;
    j_d     = j_q;
    nd_d    = nd_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + cnt_t'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - cnt_t'(1);
    end
    if (cmd_i.capture) begin
      ptr_d = '0;
      nd_d  = '0;
    end else begin
      if (cmd_i.ptr_inc) begin
        ptr_d = ptr_nx;
      end
      if (cmd_i.dst_wr_new) begin
        nd_d = nd_q + cnt_t'(1);
      end
    end
    if (cmd_i.j_clr) begin
      j_d = '0;
    end else if (cmd_i.j_inc) begin
      j_d = j_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      j_q     <= '0;
      nd_q    <= '0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      j_q     <= j_d;
      nd_q    <= nd_d;
    end
  end

  // operand and current entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      val_q <= VALUE_BITS'($unsigned(in_data_i.item_value));
    end
    if (cmd_i.cur_load) begin
      cur_q <= ent_rd_q;
    end
  end

  // status
  assign sts_o.full            = (count_q == cnt_t'(DEPTH));
  assign sts_o.cnt_zero        = (count_q == '0);
  assign sts_o.ptr_at_cnt      = (ptr_q == count_q);
  assign sts_o.ptr_next_at_cnt = (ptr_nx == count_q);
  assign sts_o.ent_match       = (ent_rd_q == val_q);
  assign sts_o.j_at_nd         = (j_q == nd_q);
  assign sts_o.dst_match       = (dst_rd_q.value == cur_q);
  assign sts_o.j_last          = (j_nx == nd_q);
  assign sts_o.out_free        = !out_valid_q || !out_stall_i;

  // result register
  always_comb begin
    out_data_d             = out_data_q;
    out_data_d.status      = cmd_i.res_status;
    out_data_d.list_length = LEN_W'(count_q);
    case (cmd_i.res_kind)
      RES_DISTINCT: begin
        out_data_d.entry_value = to_out(dst_rd_q.value);
        out_data_d.occurrences = OCC_W'(dst_rd_q.occ);
        out_data_d.last_result = (j_nx == nd_q);
      end
      RES_EMPTY: begin
        out_data_d.entry_value = '0;
        out_data_d.occurrences = '0;
        out_data_d.last_result = 1'b1;
      end
      default: begin
        out_data_d.entry_value = to_out(val_q);
        out_data_d.occurrences = '0;
        out_data_d.last_result = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hw/rtl/ordered_list_append_remove_report.sv
// append: the operand is captured and, unless the list is full, written behind the last
// entry; remove: a scan of the entry store for the first match, then a read/write shift
// report: each entry is searched for in the distinct table entry by entry, then one
// result per distinct value is emitted; one item in flight at a time
// reset clears the entry count and all control; the stores need no clearing
// ----------------------------------------------------------------------------
// ordered_list_append_remove_report
// ordered list of signed values with append, remove first match and a report
// of distinct values with their occurrence counts
// ----------------------------------------------------------------------------
module ordered_list_append_remove_report
  import olar_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  olar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  olar_dp #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
